// ----- rtl/context_slot_allocator_top_defines.svh -----
// ----------------------------------------------------------------------------
// Context slot allocator assertion macros
// Assertion wrappers that compile to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef CONTEXT_SLOT_ALLOCATOR_TOP_DEFINES_SVH
`define CONTEXT_SLOT_ALLOCATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define CSA_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("context slot allocator check failed");
`define CSA_ASSERT_RST(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("context slot allocator reset check failed");
`else
`define CSA_ASSERT(name, prop)
`define CSA_ASSERT_RST(name, prop)
`endif

`endif

// ----- rtl/csa_pkg.sv -----
// ----------------------------------------------------------------------------
// Context slot allocator package
// Word types, field codes and default sizes shared by the allocator modules.
// ----------------------------------------------------------------------------
package csa_pkg;

  localparam int SLOT_COUNT_DEF = 320;
  localparam int SLOT_BYTES_DEF = 64;
  localparam int ADDR_W         = 32;
  localparam int WORD_BITS      = 32;
  localparam int BIT_IDX_W      = 5;

  localparam logic OP_CREATE      = 1'b0;
  localparam logic OP_RELEASE     = 1'b1;
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_NO_SLOT = 1'b1;

  typedef struct packed {
    logic              op;
    logic [ADDR_W-1:0] release_address;
  } csa_in_t;

  typedef struct packed {
    logic              status;
    logic [ADDR_W-1:0] context_address;
  } csa_out_t;

endpackage

// ----- rtl/csa_slot_div.sv -----
// ----------------------------------------------------------------------------
// Slot index divider
// Turns a region offset into a slot index by a multiply with the constant
// reciprocal of the slot size; the quotient is ready in the cycle after start.
// ----------------------------------------------------------------------------
module csa_slot_div
  import csa_pkg::*;
#(
  parameter int SLOT_BYTES = SLOT_BYTES_DEF,
  parameter int OFF_W      = 14,
  parameter int SLOT_W     = 9
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [OFF_W-1:0]  dividend,
  output logic              done,
  output logic [SLOT_W-1:0] quotient
);

  localparam int SHIFT   = OFF_W + $clog2(SLOT_BYTES);
  localparam int RECIP_W = OFF_W + 2;
  localparam int PROD_W  = OFF_W + RECIP_W;
  localparam longint unsigned RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(SLOT_BYTES) - 64'd1) / 64'(SLOT_BYTES);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

  logic              done_r;
  logic [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= start;
    end
    if (start) begin
      prod_r <= PROD_W'(dividend) * PROD_W'(RECIP);
    end
  end

  assign done     = done_r;
  assign quotient = SLOT_W'(prod_r >> SHIFT);

endmodule

// ----- rtl/context_slot_allocator_top.sv -----
// ----------------------------------------------------------------------------
// Context slot allocator
// First-fit allocator over a used map of fixed-size context slots.
//
//   Channel | Ports                             | Word
//   input   | in_valid, in_ready, in_word       | csa_in_t (op, release_address)
//   result  | out_valid, out_ready, out_word    | csa_out_t (status, context_address)
//   config  | cfg_valid, cfg_ready, cfg_region_base | region base, always ready
//
// A create steps through full-flag search and map read at the accepting edge,
// then bit search, write back and slot multiply, then base add, then the
// result is registered. A release inside the region steps through the
// reciprocal multiply, map read, bit clear and write back, result register.
// Other releases and a failed create go straight to the result register. The
// next word can be accepted once the result is registered.
// The map is read as free after reset through per-word valid bits; no clearing pass.
// One request is in work at a time; a held result blocks only the next completion.
// ----------------------------------------------------------------------------
`include "context_slot_allocator_top_defines.svh"

module context_slot_allocator_top
  import csa_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int SLOT_BYTES = SLOT_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  csa_in_t           in_word,
  output logic              out_valid,
  input  logic              out_ready,
  output csa_out_t          out_word,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [ADDR_W-1:0] cfg_region_base
);

  localparam int NW           = (SLOT_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_IDX_W   = (NW > 1) ? $clog2(NW) : 1;
  localparam int SLOT_W       = WORD_IDX_W + BIT_IDX_W;
  localparam int BYTES_W      = $clog2(SLOT_BYTES + 1);
  localparam int PROD_W       = SLOT_W + BYTES_W;
  localparam int REGION_BYTES = SLOT_COUNT * SLOT_BYTES;
  localparam int OFF_W        = (REGION_BYTES > 1) ? $clog2(REGION_BYTES) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_C_FIND, S_C_ADD, S_R_DIV, S_R_CLR, S_RESP
  } csa_state_t;

  csa_state_t            state_r, state_nxt;
  logic [ADDR_W-1:0]     base_r;
  logic [NW-1:0]         full_r, full_nxt;
  logic [NW-1:0]         row_valid_r, row_valid_nxt;
  logic [WORD_IDX_W-1:0] widx_r, widx_nxt;
  logic [SLOT_W-1:0]     slot_r, slot_nxt;
  logic [PROD_W-1:0]     prod_r, prod_nxt;
  logic                  res_status_r, res_status_nxt;
  logic [ADDR_W-1:0]     res_addr_r, res_addr_nxt;
  logic                  out_valid_r, out_valid_nxt;
  csa_out_t              out_word_r, out_word_nxt;

  logic [WORD_BITS-1:0]  map_mem [NW];
  logic [WORD_BITS-1:0]  rd_word_r;
  logic                  rd_valid_r;
  logic                  mem_re, mem_we;
  logic [WORD_IDX_W-1:0] mem_raddr, mem_waddr;
  logic [WORD_BITS-1:0]  mem_wdata;

  logic                  in_fire;
  logic                  free_found;
  logic [WORD_IDX_W-1:0] free_widx;
  logic [WORD_BITS-1:0]  cur_word, pad_mask, eff_word, bit_mask, clr_mask;
  logic [BIT_IDX_W-1:0]  free_bit;
  logic [SLOT_W-1:0]     create_slot;
  logic [ADDR_W-1:0]     rel_off;
  logic                  in_region;
  logic                  div_start, div_done;
  logic [SLOT_W-1:0]     div_quot;

  assign in_fire   = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_comb begin
    free_found = 1'b0;
    free_widx  = '0;
    for (int i = NW - 1; i >= 0; i--) begin
      if (!full_r[i]) begin
        free_found = 1'b1;
        free_widx  = WORD_IDX_W'(i);
      end
    end
  end

  assign cur_word = rd_valid_r ? rd_word_r : '0;

  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      pad_mask[j] = ({1'b0, widx_r, BIT_IDX_W'(j)} >= (SLOT_W + 1)'(SLOT_COUNT));
    end
  end

  assign eff_word = cur_word | pad_mask;

  always_comb begin
    free_bit = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (!eff_word[j]) begin
        free_bit = BIT_IDX_W'(j);
      end
    end
  end

  assign bit_mask    = {{(WORD_BITS-1){1'b0}}, 1'b1} << free_bit;
  assign clr_mask    = ~({{(WORD_BITS-1){1'b0}}, 1'b1} << slot_r[BIT_IDX_W-1:0]);
  assign create_slot = {widx_r, free_bit};

  assign rel_off   = in_word.release_address - base_r;
  assign in_region = (base_r != '0) && (in_word.release_address >= base_r) &&
                     (rel_off < ADDR_W'(REGION_BYTES));

  csa_slot_div #(
    .SLOT_BYTES (SLOT_BYTES),
    .OFF_W      (OFF_W),
    .SLOT_W     (SLOT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rel_off[OFF_W-1:0]),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_comb begin
    state_nxt      = state_r;
    widx_nxt       = widx_r;
    slot_nxt       = slot_r;
    prod_nxt       = prod_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    full_nxt       = full_r;
    row_valid_nxt  = row_valid_r;
    out_valid_nxt  = out_valid_r;
    out_word_nxt   = out_word_r;
    mem_re         = 1'b0;
    mem_raddr      = '0;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    div_start      = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_status_nxt = STATUS_OK;
          res_addr_nxt   = '0;
          if (in_word.op == OP_CREATE) begin
            if (free_found) begin
              mem_re    = 1'b1;
              mem_raddr = free_widx;
              widx_nxt  = free_widx;
              state_nxt = S_C_FIND;
            end else begin
              res_status_nxt = STATUS_NO_SLOT;
              state_nxt      = S_RESP;
            end
          end else if (in_region) begin
            div_start = 1'b1;
            state_nxt = S_R_DIV;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end
      S_C_FIND: begin
        mem_we                = 1'b1;
        mem_waddr             = widx_r;
        mem_wdata             = cur_word | bit_mask;
        row_valid_nxt[widx_r] = 1'b1;
        full_nxt[widx_r]      = &(eff_word | bit_mask);
        prod_nxt              = PROD_W'(create_slot) * PROD_W'(SLOT_BYTES);
        state_nxt             = S_C_ADD;
      end
      S_C_ADD: begin
        res_addr_nxt = base_r + ADDR_W'(prod_r);
        state_nxt    = S_RESP;
      end
      S_R_DIV: begin
        if (div_done) begin
          slot_nxt  = div_quot;
          mem_re    = 1'b1;
          mem_raddr = div_quot[SLOT_W-1:BIT_IDX_W];
          state_nxt = S_R_CLR;
        end
      end
      S_R_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = slot_r[SLOT_W-1:BIT_IDX_W];
        mem_wdata = cur_word & clr_mask;
        row_valid_nxt[slot_r[SLOT_W-1:BIT_IDX_W]] = 1'b1;
        full_nxt[slot_r[SLOT_W-1:BIT_IDX_W]]      = 1'b0;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt                = 1'b1;
          out_word_nxt.status          = res_status_r;
          out_word_nxt.context_address = res_addr_r;
          state_nxt                    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      base_r      <= '0;
      full_r      <= '0;
      row_valid_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      full_r      <= full_nxt;
      row_valid_r <= row_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        base_r <= cfg_region_base;
      end
    end
    widx_r       <= widx_nxt;
    slot_r       <= slot_nxt;
    prod_r       <= prod_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    out_word_r   <= out_word_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_word_r  <= map_mem[mem_raddr];
      rd_valid_r <= row_valid_r[mem_raddr];
    end
  end

  `CSA_ASSERT(a_full_on_no_slot, (state_r == S_RESP && res_status_r == STATUS_NO_SLOT) |-> &full_r)
  `CSA_ASSERT(a_create_marks_row, (state_r == S_C_FIND) |=> row_valid_r[$past(widx_r)])
  `CSA_ASSERT(a_div_done_while_waiting, div_done |-> (state_r == S_R_DIV))
  `CSA_ASSERT(a_no_read_during_write, mem_we |-> !mem_re)
  `CSA_ASSERT_RST(a_reset_idle, !rst_n |=> (state_r == S_IDLE && !out_valid_r))

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// Context slot allocator testbench
// Drives create and release words under random sender gaps and receiver
// stalls, predicts each result from a private copy of the used map and the
// region base, and checks every result word in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import csa_pkg::*;

  localparam int REGION_BYTES = SLOT_COUNT_DEF * SLOT_BYTES_DEF;

  typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  class slot_map_tracker;
    bit              used [SLOT_COUNT_DEF];
    bit [ADDR_W-1:0] base;
    csa_out_t        pending_results [$];
    int              errors;
    int              creates_ok;
    int              creates_full;
    int              slots_freed;

    function void note_request(csa_in_t w);
      csa_out_t  r;
      int        idx;
      bit [63:0] off;
      r.status          = STATUS_OK;
      r.context_address = '0;
      if (w.op == OP_CREATE) begin
        idx = -1;
        for (int i = 0; i < SLOT_COUNT_DEF; i++) begin
          if (!used[i] && idx < 0) idx = i;
        end
        if (idx < 0) begin
          r.status = STATUS_NO_SLOT;
          creates_full++;
        end else begin
          used[idx]         = 1'b1;
          r.context_address = base + ADDR_W'(idx * SLOT_BYTES_DEF);
          creates_ok++;
        end
      end else if (base != 0 && w.release_address >= base) begin
        off = 64'(w.release_address) - 64'(base);
        if (off < 64'(REGION_BYTES)) begin
          if (used[off / SLOT_BYTES_DEF]) slots_freed++;
          used[off / SLOT_BYTES_DEF] = 1'b0;
        end
      end
      pending_results.push_back(r);
    endfunction

    function void check_result(csa_out_t got);
      csa_out_t want;
      if (pending_results.size() == 0) begin
        $error("result word with nothing pending: status %0d, context_address %h",
               got.status, got.context_address);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.context_address !== want.context_address) begin
        $error("context_address: expected %h, actual %h",
               want.context_address, got.context_address);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  csa_in_t           in_word = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  csa_out_t          out_word;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [ADDR_W-1:0] cfg_region_base = '0;

  slot_map_tracker tracker = new();
  rx_mode_t        rx_mode = RX_ALWAYS;
  int              rx_left = 0;
  int              burst_left = 0;
  int              base_settings = 0;

  context_slot_allocator_top u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_word         (in_word),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_word        (out_word),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_region_base (cfg_region_base)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(20, 300);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_ALWAYS: out_ready <= 1'b1;
      RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready <= ($urandom_range(0, 7) == 0);
      default:   out_ready <= (rx_left % 5) < 3;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) tracker.check_result(out_word);
  end

  task automatic send_word(csa_in_t w);
    in_word  <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    tracker.note_request(w);
  endtask

  task automatic pause_sender(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.pending_results.size() != 0);
  endtask

  task automatic write_base(logic [ADDR_W-1:0] value);
    cfg_region_base <= value;
    cfg_valid       <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    tracker.base = value;
    base_settings++;
  endtask

  task automatic send_create();
    csa_in_t w;
    w.op              = OP_CREATE;
    w.release_address = $urandom;
    send_word(w);
  endtask

  task automatic send_release(logic [ADDR_W-1:0] addr);
    csa_in_t w;
    w.op              = OP_RELEASE;
    w.release_address = addr;
    send_word(w);
  endtask

  function automatic logic [ADDR_W-1:0] pick_release_address();
    int unsigned kind;
    int unsigned idx;
    kind = $urandom_range(0, 9);
    idx  = $urandom_range(0, SLOT_COUNT_DEF - 1);
    if (kind <= 5) begin
      for (int t = 0; t < 8 && !tracker.used[idx]; t++) begin
        idx = $urandom_range(0, SLOT_COUNT_DEF - 1);
      end
      return tracker.base + ADDR_W'(idx * SLOT_BYTES_DEF) + $urandom_range(0, SLOT_BYTES_DEF - 1);
    end
    if (kind == 6) return tracker.base + $urandom_range(0, REGION_BYTES - 1);
    if (kind == 7) begin
      if ($urandom_range(0, 1) == 1) return tracker.base - $urandom_range(1, 64);
      return tracker.base + REGION_BYTES + $urandom_range(0, 63);
    end
    return $urandom;
  endfunction

  task automatic run_random(int count, int create_pct);
    for (int n = 0; n < count; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 30);
        if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 12));
      end
      burst_left--;
      if ($urandom_range(0, 99) == 0) wait_drained();
      if ($urandom_range(1, 100) <= create_pct) begin
        send_create();
      end else begin
        send_release(pick_release_address());
      end
    end
  endtask

  initial begin
    logic [ADDR_W-1:0] phase_base [6];
    int                phase_items [6];
    int                phase_pct [6];
    phase_base  = '{32'hC000_0017, 32'hFFFF_FFFF, 32'hFFFF_B000, 32'h0, 32'h0, 32'h0000_0040};
    phase_items = '{420, 90, 140, 140, 80, 80};
    phase_pct   = '{92, 55, 55, 45, 50, 50};
    phase_base[3] = $urandom;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // With the base still unset, creates count from address zero and
    // releases are ignored.
    send_create();
    send_release(32'h0);
    send_release(32'hFFFF_FFFF);
    send_create();
    wait_drained();

    write_base(32'hC000_0017);
    send_create();
    send_release(32'hC000_0017 + 64 + 63);
    send_release(32'hC000_0017 - 1);
    send_release(32'hC000_0017 + REGION_BYTES);
    send_release(32'hC000_0017 + REGION_BYTES - 1);
    send_create();
    send_release(32'hC000_0017 + 128);
    wait_drained();

    // The top base wraps created addresses past zero.
    write_base(32'hFFFF_FFFF);
    send_create();
    send_release(32'hFFFF_FFFF);
    send_create();
    send_release(32'h0000_003F);
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      write_base(phase_base[p]);
      run_random(phase_items[p], phase_pct[p]);
      wait_drained();
    end

    repeat (40) @(posedge clk);
    $display("Run covered %0d successful creates, %0d creates on a full region and",
             tracker.creates_ok, tracker.creates_full);
    $display("%0d releases that freed a slot, over %0d region base settings.",
             tracker.slots_freed, base_settings);
    if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
      $display("** context_slot_allocator_top: PASSED **");
    end else begin
      $display("** context_slot_allocator_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timed out with %0d result words outstanding.", tracker.pending_results.size());
    $display("** context_slot_allocator_top: FAILED **");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/csa_pkg.sv
rtl/csa_slot_div.sv
rtl/context_slot_allocator_top.sv
tb/tb_top.sv
